### design/ndef_tlv_record_framer_macros.svh
// Assertion macros for the NDEF TLV record framer.
`ifndef NDEF_TLV_RECORD_FRAMER_MACROS_SVH
`define NDEF_TLV_RECORD_FRAMER_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define NTRF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define NTRF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/ntrf_pkg.sv
// Shared types and constants for the NDEF TLV record framer.
package ntrf_pkg;

    localparam int AREA_BYTES_DEF = 496;
    localparam int LEN_W          = 10;
    localparam int REC_W          = 11;
    localparam int QDEPTH         = 4;
    localparam int QPTR_W         = $clog2(QDEPTH);
    localparam int QCNT_W         = $clog2(QDEPTH + 1);
    localparam int STEP_W         = 4;

    localparam logic [7:0] TLV_TAG     = 8'h03;
    localparam logic [7:0] TLV_LONG    = 8'hFF;
    localparam logic [7:0] FLAGS_LONG  = 8'hC1;
    localparam logic [7:0] FLAGS_SHORT = 8'hD1;
    localparam logic [7:0] TYPE_LEN    = 8'h01;
    localparam logic [7:0] TERM_BYTE   = 8'hFE;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERSIZE = 2'd1,
        ST_NO_MSG   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CMD_HDR       = 2'd0,
        CMD_BODY      = 2'd1,
        CMD_ERR_SIZE  = 2'd2,
        CMD_ERR_NOMSG = 2'd3
    } cmd_kind_t;

    // One classified item, handed from front to back.
    typedef struct packed {
        cmd_kind_t          kind;
        logic [7:0]         data;      // record type or body byte
        logic [LEN_W-1:0]   blen;
        logic [REC_W-1:0]   rec_len;
        logic               long_rec;
        logic               tlv_ext;
        logic               term;      // FE follows this entry
    } entry_t;

endpackage

### design/ntrf_front.sv
// Front end: accepts input beats, tracks the open message and classifies each beat.
module ntrf_front #(
    parameter int AREA_BYTES = ntrf_pkg::AREA_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        action,
    input  logic [7:0]                  type_byte,
    input  logic [ntrf_pkg::LEN_W-1:0]  payload_len,
    input  logic [7:0]                  body_byte,
    input  logic                        q_full,
    output logic                        q_push,
    output ntrf_pkg::entry_t            q_entry
);

    logic                       open_reg, open_next;
    logic [ntrf_pkg::LEN_W-1:0] rem_reg, rem_next;
    logic                       long_rec, tlv_ext, oversize;
    logic [ntrf_pkg::REC_W-1:0] rec_len, total;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // Message size and record form
    always_comb
    begin
        long_rec = (payload_len[ntrf_pkg::LEN_W-1:8] != '0);
        rec_len  = (long_rec ? ntrf_pkg::REC_W'(7) : ntrf_pkg::REC_W'(4))
                   + ntrf_pkg::REC_W'(payload_len);
        tlv_ext  = (rec_len >= ntrf_pkg::REC_W'(255));
        total    = rec_len + (tlv_ext ? ntrf_pkg::REC_W'(5) : ntrf_pkg::REC_W'(3));
        oversize = (total > ntrf_pkg::REC_W'(AREA_BYTES));
    end

    // Classification and next message state
    always_comb
    begin
        open_next        = open_reg;
        rem_next         = rem_reg;
        q_entry.kind     = ntrf_pkg::CMD_HDR;
        q_entry.data     = type_byte;
        q_entry.blen     = payload_len;
        q_entry.rec_len  = rec_len;
        q_entry.long_rec = long_rec;
        q_entry.tlv_ext  = tlv_ext;
        q_entry.term     = 1'b0;
        if (!action)
        begin
            if (oversize)
            begin
                q_entry.kind = ntrf_pkg::CMD_ERR_SIZE;
                open_next    = 1'b0;
                rem_next     = '0;
            end
            else
            begin
                q_entry.term = (payload_len == '0);
                open_next    = (payload_len != '0);
                rem_next     = payload_len;
            end
        end
        else
        begin
            q_entry.data = body_byte;
            if (!open_reg)
            begin
                q_entry.kind = ntrf_pkg::CMD_ERR_NOMSG;
            end
            else
            begin
                q_entry.kind = ntrf_pkg::CMD_BODY;
                rem_next     = rem_reg - ntrf_pkg::LEN_W'(1);
                q_entry.term = (rem_next == '0);
                open_next    = (rem_next != '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            rem_reg  <= '0;
        end
        else if (q_push)
        begin
            open_reg <= open_next;
            rem_reg  <= rem_next;
        end
    end

endmodule

### design/ntrf_queue.sv
// Short register FIFO between the front and back ends.
module ntrf_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ntrf_pkg::entry_t push_entry,
    output logic             full,
    output logic             head_valid,
    output ntrf_pkg::entry_t head_entry,
    input  logic             pop
);

    ntrf_pkg::entry_t              mem_reg [ntrf_pkg::QDEPTH];
    logic [ntrf_pkg::QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [ntrf_pkg::QCNT_W-1:0]   cnt_reg, cnt_next;

    assign full       = (cnt_reg == ntrf_pkg::QCNT_W'(ntrf_pkg::QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + ntrf_pkg::QCNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - ntrf_pkg::QCNT_W'(1);
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + ntrf_pkg::QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + ntrf_pkg::QPTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

endmodule

### design/ntrf_back.sv
// Back end: steps through each queued entry and emits one output byte per beat.
module ntrf_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  ntrf_pkg::entry_t head_entry,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_byte,
    output logic [1:0]       status,
    output logic             last_of_run,
    output logic             message_end
);

    logic [ntrf_pkg::STEP_W-1:0] step_reg, step_next;
    logic [ntrf_pkg::STEP_W-1:0] tlv_n, q, type_pos;
    logic                        out_valid_reg;
    logic [7:0]                  byte_reg;
    ntrf_pkg::status_t           status_reg;
    logic                        last_reg, end_reg;
    logic                        advance, fire;
    logic [7:0]                  cur_byte;
    ntrf_pkg::status_t           cur_status;
    logic                        cur_last, cur_end;

    assign advance     = !out_valid_reg || !out_stall;
    assign fire        = head_valid && advance;
    assign pop         = fire && cur_last;
    assign out_valid   = out_valid_reg;
    assign out_byte    = byte_reg;
    assign status      = status_reg;
    assign last_of_run = last_reg;
    assign message_end = end_reg;

    // Byte for the current step of the head entry
    always_comb
    begin
        cur_byte   = '0;
        cur_status = ntrf_pkg::ST_OK;
        cur_last   = 1'b1;
        cur_end    = 1'b0;
        tlv_n      = head_entry.tlv_ext ? ntrf_pkg::STEP_W'(4) : ntrf_pkg::STEP_W'(2);
        q          = step_reg - tlv_n;
        type_pos   = head_entry.long_rec ? ntrf_pkg::STEP_W'(6) : ntrf_pkg::STEP_W'(3);
        case (head_entry.kind)
            ntrf_pkg::CMD_HDR:
            begin
                cur_last = 1'b0;
                if (step_reg == '0)
                    cur_byte = ntrf_pkg::TLV_TAG;
                else if (step_reg < tlv_n)
                begin
                    // TLV length: one byte, or FF and two bytes
                    if (!head_entry.tlv_ext || step_reg == ntrf_pkg::STEP_W'(3))
                        cur_byte = head_entry.rec_len[7:0];
                    else if (step_reg == ntrf_pkg::STEP_W'(1))
                        cur_byte = ntrf_pkg::TLV_LONG;
                    else
                        cur_byte = {5'b0, head_entry.rec_len[ntrf_pkg::REC_W-1:8]};
                end
                else if (q == '0)
                    cur_byte = head_entry.long_rec ? ntrf_pkg::FLAGS_LONG
                                                   : ntrf_pkg::FLAGS_SHORT;
                else if (q == ntrf_pkg::STEP_W'(1))
                    cur_byte = ntrf_pkg::TYPE_LEN;
                else if (q < type_pos)
                begin
                    // Payload length, 1 or 4 bytes big-endian
                    if (!head_entry.long_rec || q == ntrf_pkg::STEP_W'(5))
                        cur_byte = head_entry.blen[7:0];
                    else if (q == ntrf_pkg::STEP_W'(4))
                        cur_byte = {6'b0, head_entry.blen[ntrf_pkg::LEN_W-1:8]};
                    else
                        cur_byte = '0;
                end
                else if (q == type_pos)
                begin
                    cur_byte = head_entry.data;
                    cur_last = !head_entry.term;
                end
                else
                begin
                    cur_byte = ntrf_pkg::TERM_BYTE;
                    cur_end  = 1'b1;
                    cur_last = 1'b1;
                end
            end
            ntrf_pkg::CMD_BODY:
            begin
                if (step_reg == '0)
                begin
                    cur_byte = head_entry.data;
                    cur_last = !head_entry.term;
                end
                else
                begin
                    cur_byte = ntrf_pkg::TERM_BYTE;
                    cur_end  = 1'b1;
                end
            end
            ntrf_pkg::CMD_ERR_SIZE:
                cur_status = ntrf_pkg::ST_OVERSIZE;
            default:
                cur_status = ntrf_pkg::ST_NO_MSG;
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        if (fire)
            step_next = cur_last ? '0 : step_reg + ntrf_pkg::STEP_W'(1);
    end

    // Step counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (advance)
                out_valid_reg <= head_valid;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            byte_reg   <= cur_byte;
            status_reg <= cur_status;
            last_reg   <= cur_last;
            end_reg    <= cur_end;
        end
    end

endmodule

### design/ndef_tlv_record_framer.sv
// Top level of the NDEF TLV record framer: front end, queue, back end.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------------
//  in      | input     | in_valid / in_stall  | action, type_byte, payload_len, body_byte
//  out     | output    | out_valid / out_stall| out_byte, status, last_of_run, message_end
//
// Input beats are taken one per cycle until the four-entry queue fills.
// A body beat yields 1 output beat (2 on the last byte, with FE); a start beat
// yields 6 to 11 header beats (7 with FE on an empty body), one per cycle while
// out_stall is low, from the back-end step counter. Error results take one beat.
// An accepted input beat passes through the queue, then the registered output stage.
// Reset closes any open message, empties the queue and drops out_valid.
// out_stall holds the output register; input stalls only on a full queue.
`include "ndef_tlv_record_framer_macros.svh"

module ndef_tlv_record_framer #(
    parameter int AREA_BYTES = ntrf_pkg::AREA_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        action,
    input  logic [7:0]                  type_byte,
    input  logic [ntrf_pkg::LEN_W-1:0]  payload_len,
    input  logic [7:0]                  body_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [7:0]                  out_byte,
    output logic [1:0]                  status,
    output logic                        last_of_run,
    output logic                        message_end
);

    logic             q_push, q_full, q_valid, q_pop;
    ntrf_pkg::entry_t q_in, q_head;

    ntrf_front #(
        .AREA_BYTES (AREA_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .type_byte   (type_byte),
        .payload_len (payload_len),
        .body_byte   (body_byte),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (q_in)
    );

    ntrf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .head_valid (q_valid),
        .head_entry (q_head),
        .pop        (q_pop)
    );

    ntrf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (q_valid),
        .head_entry  (q_head),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .status      (status),
        .last_of_run (last_of_run),
        .message_end (message_end)
    );

    // Terminator beat is always FE and closes the run
    `NTRF_ASSERT_IMP(a_term_beat, out_valid && message_end, out_byte == ntrf_pkg::TERM_BYTE && last_of_run, "terminator beat malformed")

    // Error beats carry a zero byte and stand alone
    `NTRF_ASSERT_IMP(a_err_beat, out_valid && status != ntrf_pkg::ST_OK, out_byte == '0 && last_of_run && !message_end, "error beat malformed")

    // The back end never pops an empty queue
    `NTRF_ASSERT_IMP(a_pop_valid, q_pop, q_valid, "pop from empty queue")

endmodule
